/* hdl/dc_pkg.sv */
// ----------------------------------------------------------------------------
// dc_pkg: shared types and constants for dominance counting
// transaction payloads for the point and result channels, and the
// control group that travels along the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package dc_pkg;

	localparam int FIELD_W = 32;	// width of one coordinate field on the port
	localparam int TALLY_W = 6;	// width of a dominance tally
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x_coord;
		logic signed [FIELD_W-1:0] y_coord;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic [5:0] point_index;
		logic [5:0] dominator_count;
		logic       overflowed;
		logic       last_result;
	} result_t;

	// travelling point: valid flag and the tally it gathers on its way
	typedef struct packed {
		logic               valid;
		logic [TALLY_W-1:0] tally;
	} tag_t;

endpackage

`default_nettype wire

/* hdl/dc_cell.sv */
// ----------------------------------------------------------------------------
// dc_cell: one cell of the dominance chain
// holds one point and its tally, compares against the point passing by and
// forwards it one cell per cycle; tallies shift toward cell 0 on readout
// ----------------------------------------------------------------------------
`default_nettype none

module dc_cell #(
	parameter int COORD_BITS = 32,
	parameter int SLOT_W     = 6,
	parameter int INDEX      = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  dc_pkg::tag_t           tag_in,
	input  wire  signed [COORD_BITS-1:0] x_in,
	input  wire  signed [COORD_BITS-1:0] y_in,
	input  wire         [SLOT_W-1:0]     slot_in,
	output dc_pkg::tag_t                 tag_out,
	output logic signed [COORD_BITS-1:0] x_out,
	output logic signed [COORD_BITS-1:0] y_out,
	output logic        [SLOT_W-1:0]     slot_out,
	input  wire                          shift,
	input  wire  [dc_pkg::TALLY_W-1:0]   shift_tally,
	output logic [dc_pkg::TALLY_W-1:0]   tally
);

	localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(INDEX);

	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [dc_pkg::TALLY_W-1:0]   tally_q;
	logic                         fwd_valid_q;
	logic [dc_pkg::TALLY_W-1:0]   fwd_tally_q;
	logic signed [COORD_BITS-1:0] fwd_x_q, fwd_y_q;
	logic [SLOT_W-1:0]            fwd_slot_q;

	logic hit, held_dominated, pass_dominated;

	assign hit            = (slot_in == SLOT_ID);
	assign held_dominated = (x_in >= x_q) && (y_in >= y_q);
	assign pass_dominated = (x_q >= x_in) && (y_q >= y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= tag_in.valid && !hit;
		end
	end

	always_ff @(posedge clk) begin
		fwd_x_q    <= x_in;
		fwd_y_q    <= y_in;
		fwd_slot_q <= slot_in;
		if (pass_dominated && tag_in.tally != dc_pkg::TALLY_MAX) begin
			fwd_tally_q <= tag_in.tally + 1'b1;
		end else begin
			fwd_tally_q <= tag_in.tally;
		end
		if (shift) begin
			tally_q <= shift_tally;
		end else if (tag_in.valid) begin
			if (hit) begin
				x_q     <= x_in;
				y_q     <= y_in;
				tally_q <= tag_in.tally;
			end else if (held_dominated && tally_q != dc_pkg::TALLY_MAX) begin
				tally_q <= tally_q + 1'b1;
			end
		end
	end

	assign tag_out  = '{valid: fwd_valid_q, tally: fwd_tally_q};
	assign x_out    = fwd_x_q;
	assign y_out    = fwd_y_q;
	assign slot_out = fwd_slot_q;
	assign tally    = tally_q;

endmodule

`default_nettype wire

/* hdl/dominance_count_2d.sv */
// ----------------------------------------------------------------------------
// dominance_count_2d: two-dimensional dominance counting over a point set
// points enter a chain of cells; each point walks the chain to its slot,
// counting the held points that dominate it and bumping those it dominates
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                payload
//   point     in         point_valid/point_stall  dc_pkg::point_t
//   result    out        result_valid/result_stall dc_pkg::result_t
//
// - loading takes one point per cycle until the point marked last
// - after the last point the chain drains, long enough for a point to walk
//   to the far end of the chain, then results leave one per cycle, unless
//   stalled, from cell 0 while the cell tallies shift toward it
// - point_stall is high from the last point until the final result is loaded
// - a stalled result holds in the output register and freezes the readout
// - reset clears control state only; no clearing pass is needed
`default_nettype none

module dominance_count_2d #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   point_valid,
	output logic                  point_stall,
	input  wire  dc_pkg::point_t  point,
	output logic                  result_valid,
	input  wire                   result_stall,
	output dc_pkg::result_t       result
);

	localparam int SLOT_W = $clog2(MAX_POINTS);
	localparam int HELD_W = $clog2(MAX_POINTS + 1);
	localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(MAX_POINTS);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [HELD_W-1:0]   held_q;
	logic                ovf_q;
	logic [HELD_W-1:0]   drain_q;
	logic [SLOT_W-1:0]   emit_q;
	logic                res_valid_q;
	dc_pkg::result_t     res_q;

	logic                point_take;
	logic                room;
	logic                shift;
	logic                emit_last;

	// chain wiring: entry 0 is the injected point, entry k+1 leaves cell k
	dc_pkg::tag_t                 tag_c   [MAX_POINTS+1];
	logic signed [COORD_BITS-1:0] x_c     [MAX_POINTS+1];
	logic signed [COORD_BITS-1:0] y_c     [MAX_POINTS+1];
	logic [SLOT_W-1:0]            slot_c  [MAX_POINTS+1];
	logic [dc_pkg::TALLY_W-1:0]   tally_c [MAX_POINTS];

	// coordinate width: cut to COORD_BITS or sign extend the port field
	generate
		if (COORD_BITS <= dc_pkg::FIELD_W) begin : g_cut
			assign x_c[0] = point.x_coord[COORD_BITS-1:0];
			assign y_c[0] = point.y_coord[COORD_BITS-1:0];
		end else begin : g_ext
			assign x_c[0] = {{(COORD_BITS-dc_pkg::FIELD_W){point.x_coord[dc_pkg::FIELD_W-1]}},
				point.x_coord};
			assign y_c[0] = {{(COORD_BITS-dc_pkg::FIELD_W){point.y_coord[dc_pkg::FIELD_W-1]}},
				point.y_coord};
		end
	endgenerate

	assign point_stall = (state_q != ST_LOAD);
	assign point_take  = point_valid && !point_stall;
	assign room        = (held_q != HELD_MAX);

	// a point enters cell 0 in the cycle it is taken if there is room, tally starting at zero
	assign tag_c[0]  = '{valid: point_take && room, tally: '0};
	assign slot_c[0] = held_q[SLOT_W-1:0];

	generate
		for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
			logic [dc_pkg::TALLY_W-1:0] next_tally;
			if (k + 1 < MAX_POINTS) begin : g_mid
				assign next_tally = tally_c[k+1];
			end else begin : g_end
				assign next_tally = '0;
			end
			dc_cell #(
				.COORD_BITS (COORD_BITS),
				.SLOT_W     (SLOT_W),
				.INDEX      (k)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.tag_in      (tag_c[k]),
				.x_in        (x_c[k]),
				.y_in        (y_c[k]),
				.slot_in     (slot_c[k]),
				.tag_out     (tag_c[k+1]),
				.x_out       (x_c[k+1]),
				.y_out       (y_c[k+1]),
				.slot_out    (slot_c[k+1]),
				.shift       (shift),
				.shift_tally (next_tally),
				.tally       (tally_c[k])
			);
		end
	endgenerate

	// readout advances whenever the output register is free or being taken
	assign shift     = (state_q == ST_EMIT) && (!res_valid_q || !result_stall);
	assign emit_last = (HELD_W'(emit_q) + HELD_W'(1)) == held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			held_q      <= '0;
			ovf_q       <= 1'b0;
			drain_q     <= '0;
			emit_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// output register: loaded by a readout step, freed when taken
			if (shift) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (point_take) begin
						if (room) begin
							held_q <= held_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (point.last_point) begin
							drain_q <= HELD_W'(MAX_POINTS - 1);
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// wait until every point in flight has reached its slot
					if (drain_q == '0) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (shift) begin
						emit_q <= emit_q + 1'b1;
						if (emit_last) begin
							held_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result payload, loaded with each readout step
	always_ff @(posedge clk) begin
		if (shift) begin
			res_q.point_index     <= 6'(emit_q);
			res_q.dominator_count <= tally_c[0];
			res_q.overflowed      <= ovf_q;
			res_q.last_result     <= emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// points are never taken while the set is draining or reading out
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !point_take)
		else $error("point taken while set busy");

	// the fill count never exceeds the chain length
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_MAX)
		else $error("held count beyond capacity");

	// a point dropped for lack of room marks the set as overflowed
	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(point_take && !room) |=> ovf_q)
		else $error("dropped point not flagged");

	// readout never starts on an empty set
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (held_q != '0))
		else $error("readout of empty set");

	// the final result of a set returns the chain to loading
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && emit_last) |=> (state_q == ST_LOAD) && (held_q == '0))
		else $error("set not closed after final result");

endmodule

`default_nettype wire
